>>> design/tpob_pkg.sv
// Shared types and constants of the two-pass Otsu binarizer.
// No dependencies; every other design file depends on this package.
package tpob_pkg;

    localparam int unsigned MaxPixels = 32768;
    localparam int unsigned Bins      = 256;

    localparam int unsigned CntW  = 16;   // bin count, pixel total
    localparam int unsigned BinW  = 8;    // gray level / bin index
    localparam int unsigned SumW  = 24;   // gray sums, up to 255 * 65535
    localparam int unsigned DiffW = 40;   // |sB*N - S*wB|
    localparam int unsigned DenW  = 32;   // wB * wF
    localparam int unsigned SqW   = 80;   // squared difference
    localparam int unsigned MulAW = 80;   // multiplicand width of the shared unit
    localparam int unsigned MulBW = 40;   // multiplier width of the shared unit
    localparam int unsigned ProdW = 112;  // product width of the shared unit

    localparam logic [BinW-1:0] BinHigh = 8'd255;
    localparam logic [BinW-1:0] BinLow  = 8'd0;

    typedef logic [CntW-1:0] t_cnt;
    typedef logic [BinW-1:0] t_bin;

endpackage

>>> design/tpob_if.sv
// Valid/ready channel interfaces: pixel input, result output, config write.
// Depends on tpob_pkg for payload types.
interface tpob_in_if;
    logic                valid;
    logic                ready;
    logic                kind;
    tpob_pkg::t_bin      pixel;
    logic                last;
    modport source (output valid, kind, pixel, last, input ready);
    modport sink   (input valid, kind, pixel, last, output ready);
endinterface

interface tpob_out_if;
    logic                valid;
    logic                ready;
    tpob_pkg::t_bin      value;
    logic                is_threshold;
    modport source (output valid, value, is_threshold, input ready);
    modport sink   (input valid, value, is_threshold, output ready);
endinterface

interface tpob_cfg_if;
    logic valid;
    logic ready;
    logic two_pass_mode;
    modport source (output valid, two_pass_mode, input ready);
    modport sink   (input valid, two_pass_mode, output ready);
endinterface

>>> design/tpob_mul.sv
// Shared shift-add multiplier, one multiplier bit per cycle, stops early
// when the remaining multiplier bits are zero. Depends on tpob_pkg.
module tpob_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [tpob_pkg::MulAW-1:0]    i_a,
    input  logic [tpob_pkg::MulBW-1:0]    i_b,
    output logic                          o_done,
    output logic [tpob_pkg::ProdW-1:0]    o_prod
);
    import tpob_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [ProdW-1:0] r_a;
    logic [MulBW-1:0] r_b;
    logic [ProdW-1:0] r_acc;

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_b == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath: one conditional add and shift a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= {{(ProdW-MulAW){1'b0}}, i_a};
            r_b   <= i_b;
            r_acc <= '0;
        end else if (r_busy && r_b != '0) begin
            if (r_b[0]) begin
                r_acc <= r_acc + r_a;
            end
            r_a <= {r_a[ProdW-2:0], 1'b0};
            r_b <= {1'b0, r_b[MulBW-1:1]};
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
endmodule

>>> design/tpob_hist.sv
// Histogram store: 256 x 16-bit memory, one write and one registered read.
// Depends on tpob_pkg.
module tpob_hist (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  tpob_pkg::t_bin    i_rd_addr,
    output tpob_pkg::t_cnt    o_rd_data,
    input  logic              i_wr_en,
    input  tpob_pkg::t_bin    i_wr_addr,
    input  tpob_pkg::t_cnt    i_wr_data
);
    import tpob_pkg::*;

    t_cnt r_mem [Bins];
    t_cnt r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

>>> design/two_pass_otsu_binarizer.sv
// Two-pass Otsu binarizer. Binarize words: registered result, 1 word/cycle
// unless the result is stalled. Histogram words: memory read-modify-write
// each, input not ready during the write. A last word starts the threshold
// search: 2 scans of 256 bins per Otsu pass, each candidate bin runs up to
// six multiplies on the shared shift-add unit, then a histogram clear. Reset
// (synchronous, active low) starts the same clear, with input not ready.
module two_pass_otsu_binarizer #(
    parameter int unsigned MAX_PIXELS = tpob_pkg::MaxPixels
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tpob_in_if.sink     i_in,
    tpob_out_if.source  o_out,
    tpob_cfg_if.sink    i_cfg
);
    import tpob_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_INC, S_SUM_RD, S_SUM_DAT, S_SRC_RD, S_SRC_DAT,
        S_MX, S_MY, S_MD, S_MQ, S_ML, S_MR, S_NEXT
    } t_state;

    t_state              r_state;
    t_bin                r_t;
    t_bin                r_pix;
    logic                r_last;
    t_cnt                r_total;
    t_bin                r_thr_cur;
    logic                r_two_pass;
    logic                r_pass;
    t_bin                r_first;
    t_cnt                r_below;
    logic [SumW-1:0]     r_s;
    t_cnt                r_wb;
    logic [SumW-1:0]     r_sb;
    logic [DiffW-1:0]    r_x;
    logic [DiffW-1:0]    r_a;
    logic [DenW-1:0]     r_den;
    logic [SqW-1:0]      r_q;
    logic [ProdW-1:0]    r_l;
    logic [SqW-1:0]      r_best_q;
    logic [DenW-1:0]     r_best_den;
    t_bin                r_best_t;
    logic                r_out_valid;
    t_bin                r_out_value;
    logic                r_out_thr;

    logic                mul_start;
    logic [MulAW-1:0]    mul_a;
    logic [MulBW-1:0]    mul_b;
    logic                mul_done;
    logic [ProdW-1:0]    mul_prod;

    logic                rd_en;
    t_bin                rd_addr;
    t_cnt                rd_data;
    logic                wr_en;
    t_bin                wr_addr;
    t_cnt                wr_data;

    t_cnt                eff_h;
    t_cnt                n_wb;
    logic [SumW-1:0]     n_sb;
    logic [SumW-1:0]     t_times_h;
    logic [DiffW-1:0]    y_val;
    logic                in_acc;
    logic                out_free;
    logic                out_load;

    // channel handshakes
    assign out_free    = !r_out_valid || o_out.ready;
    assign i_in.ready  = (r_state == S_IDLE) && out_free;
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid        = r_out_valid;
    assign o_out.value        = r_out_value;
    assign o_out.is_threshold = r_out_thr;

    // result register loads on a binarize word or the final threshold
    assign out_load = ((r_state == S_IDLE) && in_acc && i_in.kind)
                   || ((r_state == S_NEXT) && (r_t == BinHigh) && !(!r_pass && r_two_pass));

    // bin count as seen by the current pass (second pass merges low bins)
    always_comb begin
        eff_h = rd_data;
        if (r_pass) begin
            if (r_t < r_first) begin
                eff_h = '0;
            end else if (r_t == r_first) begin
                eff_h = r_below + rd_data;
            end
        end
    end
    assign t_times_h = SumW'(r_t) * SumW'(eff_h);
    assign n_wb      = r_wb + eff_h;
    assign n_sb      = r_sb + t_times_h;
    assign y_val     = mul_prod[DiffW-1:0];

    // memory port selection
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_t;
        wr_en   = 1'b0;
        wr_addr = r_t;
        wr_data = '0;
        unique case (r_state)
            S_CLEAR: begin
                wr_en = 1'b1;
            end
            S_IDLE: begin
                rd_en   = 1'b1;
                rd_addr = i_in.pixel;
            end
            S_INC: begin
                wr_en   = 1'b1;
                wr_addr = r_pix;
                wr_data = rd_data + 1'b1;
            end
            S_SUM_RD, S_SRC_RD: begin
                rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // operand selection for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_SRC_DAT: begin
                mul_a = MulAW'(n_sb);
                mul_b = MulBW'(r_total);
            end
            S_MX: begin
                mul_a = MulAW'(r_s);
                mul_b = MulBW'(r_wb);
            end
            S_MY: begin
                mul_a = MulAW'(r_wb);
                mul_b = MulBW'(r_total - r_wb);
            end
            S_MD: begin
                mul_a = MulAW'(r_a);
                mul_b = MulBW'(r_a);
            end
            S_MQ: begin
                mul_a = MulAW'(mul_prod[SqW-1:0]);
                mul_b = MulBW'(r_best_den);
            end
            S_ML: begin
                mul_a = MulAW'(r_best_q);
                mul_b = MulBW'(r_den);
            end
            default: begin
            end
        endcase
    end

    // start the next multiply when entering its wait state
    always_comb begin
        mul_start = 1'b0;
        unique case (r_state)
            S_SRC_DAT: mul_start = (n_wb != '0) && (n_wb < r_total);
            S_MX:      mul_start = mul_done;
            S_MY:      mul_start = mul_done && (r_x != y_val);
            S_MD, S_MQ, S_ML: mul_start = mul_done;
            default:   mul_start = 1'b0;
        endcase
    end

    tpob_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    tpob_hist u_hist (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    // sequencer with registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_t         <= '0;
            r_total     <= '0;
            r_thr_cur   <= '0;
            r_two_pass  <= 1'b1;
            r_pass      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_two_pass <= i_cfg.two_pass_mode;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_t <= r_t + 1'b1;
                    if (r_t == BinHigh) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_pix  <= i_in.pixel;
                    r_last <= i_in.last;
                    if (in_acc) begin
                        if (i_in.kind) begin
                            r_out_thr   <= 1'b0;
                            r_out_value <= (i_in.pixel > r_thr_cur) ? BinHigh : BinLow;
                        end else if (32'(r_total) < MAX_PIXELS) begin
                            r_state <= S_INC;
                        end else if (i_in.last) begin
                            r_t     <= '0;
                            r_pass  <= 1'b0;
                            r_s     <= '0;
                            r_below <= '0;
                            r_state <= S_SUM_RD;
                        end
                    end
                end
                S_INC: begin
                    r_total <= r_total + 1'b1;
                    if (r_last) begin
                        r_t     <= '0;
                        r_pass  <= 1'b0;
                        r_s     <= '0;
                        r_below <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_SUM_RD: begin
                    r_state <= S_SUM_DAT;
                end
                S_SUM_DAT: begin
                    r_s <= r_s + t_times_h;
                    if (r_t < r_first) begin
                        r_below <= r_below + rd_data;
                    end
                    r_t <= r_t + 1'b1;
                    if (r_t == BinHigh) begin
                        r_wb       <= '0;
                        r_sb       <= '0;
                        r_below    <= '0;
                        r_best_q   <= '0;
                        r_best_den <= DenW'(1);
                        r_best_t   <= '0;
                        r_state    <= S_SRC_RD;
                    end else begin
                        r_state <= S_SUM_RD;
                    end
                end
                S_SRC_RD: begin
                    r_state <= S_SRC_DAT;
                end
                S_SRC_DAT: begin
                    r_wb <= n_wb;
                    r_sb <= n_sb;
                    if (r_t < r_first) begin
                        r_below <= r_below + rd_data;
                    end
                    r_state <= mul_start ? S_MX : S_NEXT;
                end
                S_MX: begin
                    if (mul_done) begin
                        r_x     <= mul_prod[DiffW-1:0];
                        r_state <= S_MY;
                    end
                end
                S_MY: begin
                    if (mul_done) begin
                        r_a     <= (r_x > y_val) ? r_x - y_val : y_val - r_x;
                        r_state <= (r_x != y_val) ? S_MD : S_NEXT;
                    end
                end
                S_MD: begin
                    if (mul_done) begin
                        r_den   <= mul_prod[DenW-1:0];
                        r_state <= S_MQ;
                    end
                end
                S_MQ: begin
                    if (mul_done) begin
                        r_q     <= mul_prod[SqW-1:0];
                        r_state <= S_ML;
                    end
                end
                S_ML: begin
                    if (mul_done) begin
                        r_l     <= mul_prod;
                        r_state <= S_MR;
                    end
                end
                S_MR: begin
                    if (mul_done) begin
                        // strict compare keeps the first maximum
                        if (r_l > mul_prod) begin
                            r_best_q   <= r_q;
                            r_best_den <= r_den;
                            r_best_t   <= r_t;
                        end
                        r_state <= S_NEXT;
                    end
                end
                S_NEXT: begin
                    r_t <= r_t + 1'b1;
                    if (r_t != BinHigh) begin
                        r_state <= S_SRC_RD;
                    end else if (!r_pass && r_two_pass) begin
                        r_pass  <= 1'b1;
                        r_first <= r_best_t;
                        r_s     <= '0;
                        r_below <= '0;
                        r_state <= S_SUM_RD;
                    end else begin
                        r_thr_cur   <= r_best_t;
                        r_out_thr   <= 1'b1;
                        r_out_value <= r_best_t;
                        r_total     <= '0;
                        r_state     <= S_CLEAR;
                    end
                end
                default: begin
                    r_state <= S_CLEAR;
                end
            endcase
        end
    end
endmodule

>>> design/tpob_checker.sv
// Port-level checks of the two-pass Otsu binarizer and their bind.
// Depends on tpob_pkg and the top level two_pass_otsu_binarizer.
module tpob_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_in_kind,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input tpob_pkg::t_bin      i_out_value,
    input logic                i_out_is_thr
);
    import tpob_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value)
            && $stable(i_out_is_thr))
        else $error("result word changed while stalled");

    // a binarized word is black or white
    a_bin_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_is_thr |-> i_out_value == BinLow || i_out_value == BinHigh)
        else $error("binarized word is neither 0 nor 255");

    // a binarize word gives its result in the next cycle
    a_bin_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_kind |=> i_out_valid && !i_out_is_thr)
        else $error("binarize word gave no result");

    // histogram clear after reset keeps the input closed
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_in_ready && !i_out_valid)
        else $error("ready or valid right after reset");
endmodule

bind two_pass_otsu_binarizer tpob_checker u_tpob_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_kind    (i_in.kind),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_value  (o_out.value),
    .i_out_is_thr (o_out.is_threshold)
);
